// ----- src/tspm_pkg.sv -----
// ----------------------------------------------------------------------------
// tspm_pkg
// Types and constants shared by the tile/sprite pixel mux and its sprite unit.
// ----------------------------------------------------------------------------
package tspm_pkg;

	localparam int SPRITE_SLOTS_DEF  = 8;
	localparam int SCREEN_WIDTH_DEF  = 256;
	localparam int SCREEN_HEIGHT_DEF = 240;

	localparam int COORD_W      = 8;
	localparam int SLOT_FIELD_W = 3;
	localparam int SLOT_CMP_W   = 5;
	localparam int ACT_W        = 4;

	localparam logic [ACT_W-1:0]   ACT_FULL = 4'd8;
	localparam logic [COORD_W-1:0] COL_NO_HIT = 8'hFF;

	localparam logic REQ_DOT  = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	localparam int MASK_BG_LEFT = 1;
	localparam int MASK_SP_LEFT = 2;
	localparam int MASK_BG_EN   = 3;
	localparam int MASK_SP_EN   = 4;

	localparam int ATTR_BEHIND = 5;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  slot;
		logic [7:0]  sprite_x;
		logic [7:0]  sprite_attr;
		logic [15:0] sprite_pattern;
		logic        sprite0_in_line;
		logic [63:0] bg_shifters;
		logic [2:0]  fine_x;
		logic        line_start;
		logic        first_scanline;
	} tspm_in_t;

	typedef struct packed {
		logic [4:0] palette_index;
		logic [7:0] dot_col;
		logic [7:0] dot_row;
		logic       sprite0_hit;
		logic       frame_done;
	} tspm_out_t;

	typedef struct packed {
		logic [1:0] pat;
		logic [1:0] pal;
		logic       behind;
		logic       zero;
	} spr_pix_t;

endpackage

// ----- src/tile_sprite_pixel_mux.sv -----
// ----------------------------------------------------------------------------
// tile_sprite_pixel_mux
// Per-dot pixel stage: background/sprite select, clipping and priority mux.
// ----------------------------------------------------------------------------
//  channel  | signals                      | moves
//  ---------+------------------------------+----------------------------------
//  in       | in_valid, in_ready, in_data  | one dot or sprite load transaction
//  out      | out_valid, out_ready, out_data | one pixel per dot transaction
//  cfg      | cfg_we, cfg_wdata            | render_mask write, no handshake
//
//  One transaction per cycle unless the output stalls; a dot yields its
//  pixel via the input register, then the result register. Loads yield nothing.
//  The sprite counters and coordinates update in the cycle an item leaves the
//  input register, so items run back to back with no bubble.
//  Reset clears sprite slots, counters and render_mask.
//  A stalled output holds a dot in the input register; in_ready drops only then.
// ----------------------------------------------------------------------------
module tile_sprite_pixel_mux import tspm_pkg::*; #(
	parameter int SPRITE_SLOTS  = SPRITE_SLOTS_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  tspm_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output tspm_out_t  out_data
);

	localparam logic [COORD_W-1:0] COL_END = COORD_W'(SCREEN_WIDTH - 1);
	localparam logic [COORD_W-1:0] ROW_END = COORD_W'(SCREEN_HEIGHT - 1);

	logic [7:0]         mask_q;
	tspm_in_t           in_s1;
	logic               valid_s1;
	tspm_out_t          out_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;

	logic               is_load;
	logic               fire_s1;
	logic               dot_fire;
	spr_pix_t           spix;
	logic [COORD_W-1:0] col_cur;
	logic [COORD_W-1:0] row_cur;
	logic               left;
	logic               bg_en;
	logic               sp_en;
	logic [3:0]         bbit;
	logic [15:0]        sh_plo;
	logic [15:0]        sh_phi;
	logic [15:0]        sh_alo;
	logic [15:0]        sh_ahi;
	logic [1:0]         bpat;
	logic [1:0]         bpal;
	logic [1:0]         spat;
	logic [4:0]         bidx;
	logic [4:0]         sidx;
	tspm_out_t          res;

	assign is_load   = (in_s1.req_type == REQ_LOAD);
	assign fire_s1   = valid_s1 && (is_load || !out_valid_q || out_ready);
	assign dot_fire  = fire_s1 && !is_load;
	assign in_ready  = !valid_s1 || fire_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	tspm_sprite #(
		.SPRITE_SLOTS(SPRITE_SLOTS)
	) u_sprite (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_en     (fire_s1 && is_load),
		.load_slot   (in_s1.slot),
		.load_x      (in_s1.sprite_x),
		.load_attr   (in_s1.sprite_attr),
		.load_pattern(in_s1.sprite_pattern),
		.load_zero   (in_s1.sprite0_in_line),
		.dot_en      (dot_fire),
		.line_start  (in_s1.line_start),
		.pix         (spix)
	);

	always_comb begin
		col_cur = in_s1.line_start ? '0 : col_q;
		row_cur = (in_s1.line_start && in_s1.first_scanline) ? '0 : row_q;
		left    = (col_cur[COORD_W-1:3] == '0);
		bg_en   = mask_q[MASK_BG_EN];
		sp_en   = mask_q[MASK_SP_EN];

		bbit   = {1'b1, ~in_s1.fine_x};
		sh_plo = in_s1.bg_shifters[15:0];
		sh_phi = in_s1.bg_shifters[31:16];
		sh_alo = in_s1.bg_shifters[47:32];
		sh_ahi = in_s1.bg_shifters[63:48];
		bpat   = {sh_phi[bbit], sh_plo[bbit]};
		bpal   = {sh_ahi[bbit], sh_alo[bbit]};
		if (!bg_en || (left && !mask_q[MASK_BG_LEFT])) begin
			bpat = 2'b00;
		end
		bidx = (bpat != 2'b00) ? {1'b0, bpal, bpat} : 5'd0;

		spat = spix.pat;
		if (!sp_en || in_s1.first_scanline || (left && !mask_q[MASK_SP_LEFT])) begin
			spat = 2'b00;
		end
		sidx = {1'b1, spix.pal, spix.pat};

		res = '0;
		priority if (spat == 2'b00) begin
			res.palette_index = bidx;
		end else if (bpat != 2'b00 && spix.behind) begin
			res.palette_index = bidx;
		end else begin
			res.palette_index = sidx;
		end
		res.dot_col     = col_cur;
		res.dot_row     = row_cur;
		res.sprite0_hit = bg_en && sp_en
			&& !(!(mask_q[MASK_BG_LEFT] && mask_q[MASK_SP_LEFT]) && left)
			&& (col_cur != COL_NO_HIT) && (bpat != 2'b00) && (spat != 2'b00) && spix.zero;
		res.frame_done  = (col_cur == COL_END) && (row_cur == ROW_END);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dot_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dot_fire) begin
			out_q <= res;
		end
	end

	// advance coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (dot_fire) begin
			if (col_cur >= COL_END) begin
				col_q <= '0;
				row_q <= (row_cur >= ROW_END) ? '0 : row_cur + 1'b1;
			end else begin
				col_q <= col_cur + 1'b1;
				row_q <= row_cur;
			end
		end
	end

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but not ready");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_load) |=> !$rose(out_valid_q))
		else $error("load transaction produced a pixel");

	a_done_at_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_done) |-> (out_q.dot_col == COL_END
			&& out_q.dot_row == ROW_END))
		else $error("frame_done away from last pixel");

	a_hit_column: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.sprite0_hit) |-> (out_q.dot_col != COL_NO_HIT))
		else $error("sprite zero hit in last column");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(dot_fire && !in_s1.line_start && col_q < COL_END) |=>
			(col_q == $past(col_q) + 1'b1))
		else $error("column did not advance");

endmodule

// ----- src/tspm_sprite.sv -----
// ----------------------------------------------------------------------------
// tspm_sprite
// Sprite slot storage, X counters, activation counters and first-opaque pick.
// ----------------------------------------------------------------------------
module tspm_sprite import tspm_pkg::*; #(
	parameter int SPRITE_SLOTS = SPRITE_SLOTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load_en,
	input  logic [SLOT_FIELD_W-1:0] load_slot,
	input  logic [7:0]              load_x,
	input  logic [7:0]              load_attr,
	input  logic [15:0]             load_pattern,
	input  logic                    load_zero,
	input  logic                    dot_en,
	input  logic                    line_start,
	output spr_pix_t                pix
);

	logic [7:0]       xpos_q   [SPRITE_SLOTS];
	logic [ACT_W-1:0] active_q [SPRITE_SLOTS];
	logic [2:0]       attr_q   [SPRITE_SLOTS];
	logic [15:0]      plane_q  [SPRITE_SLOTS];
	logic             has_zero_q;

	logic [ACT_W-1:0] act_arm  [SPRITE_SLOTS];
	logic [ACT_W-1:0] act_next [SPRITE_SLOTS];
	logic [1:0]       pat      [SPRITE_SLOTS];

	for (genvar g = 0; g < SPRITE_SLOTS; g++) begin : g_slot
		logic             load_hit;
		logic [ACT_W-1:0] act_base;
		logic [2:0]       bit_idx;
		logic [7:0]       plane_lo;
		logic [7:0]       plane_hi;

		assign load_hit = load_en && (SLOT_CMP_W'(load_slot) == SLOT_CMP_W'(g));

		always_comb begin
			act_base    = line_start ? '0 : active_q[g];
			act_arm[g]  = (xpos_q[g] == '0) ? ACT_FULL : act_base;
			act_next[g] = (act_arm[g] != '0) ? act_arm[g] - 1'b1 : '0;
			bit_idx     = act_next[g][2:0];
			plane_lo    = plane_q[g][7:0];
			plane_hi    = plane_q[g][15:8];
			pat[g]      = (act_arm[g] != '0) ? {plane_hi[bit_idx], plane_lo[bit_idx]} : 2'b00;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				xpos_q[g]   <= '0;
				active_q[g] <= '0;
				attr_q[g]   <= '0;
				plane_q[g]  <= '0;
			end else if (load_hit) begin
				xpos_q[g]  <= load_x;
				attr_q[g]  <= {load_attr[ATTR_BEHIND], load_attr[1:0]};
				plane_q[g] <= load_pattern;
			end else if (dot_en) begin
				xpos_q[g]   <= xpos_q[g] - 8'd1;
				active_q[g] <= act_next[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_zero_q <= 1'b0;
		end else if (load_en && load_slot == '0) begin
			has_zero_q <= load_zero;
		end
	end

	// pick the lowest opaque slot
	always_comb begin
		pix = '0;
		for (int i = SPRITE_SLOTS - 1; i >= 0; i--) begin
			if (pat[i] != 2'b00) begin
				pix.pat    = pat[i];
				pix.pal    = attr_q[i][1:0];
				pix.behind = attr_q[i][2];
				pix.zero   = (i == 0) && has_zero_q;
			end
		end
	end

endmodule
